### sv/tpfcu_pkg.sv
// ----------------------------------------------------------------------------
// tpfcu_pkg
// Types and constants shared by the two-phase field cell update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tpfcu_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int FIELD_BITS  = 17;
   localparam int GAIN_BITS   = 24;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = GAIN_BITS;

   localparam logic [FIELD_BITS-1:0] ONE_VAL = FIELD_BITS'(1 << FRAC_BITS);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRAD_GAIN    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BARRIER_GAIN = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DRIVE_GAIN   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EQUIL_CONC   = 3'd3;

   localparam logic [GAIN_BITS-1:0]  GRAD_GAIN_RST    = 24'd5518;
   localparam logic [GAIN_BITS-1:0]  BARRIER_GAIN_RST = 24'd1513;
   localparam logic [GAIN_BITS-1:0]  DRIVE_GAIN_RST   = 24'd9242;
   localparam logic [FIELD_BITS-1:0] EQUIL_CONC_RST   = 17'd26214;

   // pipeline layout
   localparam int ROOT_BITS  = 17;
   localparam int SQ_STEPS   = 4;
   localparam int SQ_STAGES  = (ROOT_BITS + SQ_STEPS - 1) / SQ_STEPS;
   localparam int QUO_BITS   = 17;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = (QUO_BITS + DIV_STEPS - 1) / DIV_STEPS;

   localparam int SQ_FIRST    = 1;
   localparam int DRV_STAGE   = SQ_FIRST + SQ_STAGES;
   localparam int ACC_STAGE   = DRV_STAGE + 1;
   localparam int CLAMP_STAGE = ACC_STAGE + 1;
   localparam int NORM_STAGE  = CLAMP_STAGE + 1;
   localparam int DIV_FIRST   = NORM_STAGE + 1;
   localparam int NUM_STAGES  = DIV_FIRST + DIV_STAGES;

   typedef struct packed {
      logic [FIELD_BITS-1:0] solid_center;
      logic [FIELD_BITS-1:0] solid_east;
      logic [FIELD_BITS-1:0] solid_west;
      logic [FIELD_BITS-1:0] solid_north;
      logic [FIELD_BITS-1:0] solid_south;
      logic [FIELD_BITS-1:0] liquid_center;
      logic [FIELD_BITS-1:0] liquid_east;
      logic [FIELD_BITS-1:0] liquid_west;
      logic [FIELD_BITS-1:0] liquid_north;
      logic [FIELD_BITS-1:0] liquid_south;
      logic [FIELD_BITS-1:0] liquid_conc;
   } req_payload_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] new_solid;
      logic [FIELD_BITS-1:0] new_liquid;
      logic                  interface_cell;
   } rsp_payload_type;

   // everything one item carries down the pipe; each stage fills its part
   typedef struct packed {
      logic                    active;
      logic [FIELD_BITS-1:0]   s0;
      logic [FIELD_BITS-1:0]   l0;
      logic signed [21:0]      lap_diff;
      logic signed [17:0]      sl_diff;
      logic signed [17:0]      cdiff;
      logic [33:0]             radicand;
      logic [20:0]             sq_rem;
      logic [ROOT_BITS-1:0]    sq_root;
      logic signed [46:0]      grad;
      logic signed [42:0]      barr;
      logic signed [42:0]      dprod;
      logic signed [60:0]      drv;
      logic signed [48:0]      acc;
      logic [FIELD_BITS-1:0]   cs;
      logic [FIELD_BITS-1:0]   cl;
      logic [17:0]             dsum;
      logic [33:0]             num_s;
      logic [33:0]             num_l;
      logic [18:0]             rem_s;
      logic [18:0]             rem_l;
      logic [QUO_BITS-1:0]     q_s;
      logic [QUO_BITS-1:0]     q_l;
   } work_type;

endpackage

`default_nettype wire

### sv/two_phase_field_cell_update_unit.sv
// ----------------------------------------------------------------------------
// two_phase_field_cell_update_unit
// Explicit two-phase field update of one grid cell from its 5-point stencil.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one cell neighborhood (solid/liquid fractions, liquid conc) per
//            transfer, valid/stall handshake.
//   rsp_*  : new solid/liquid fraction and interface flag, one per request,
//            in request order.
//   csr_*  : write-only gains and equilibrium concentration, written while
//            the unit is idle.
//   Throughput is one cell per cycle while no result is held by rsp_stall;
//   the depth is set by the bit-serial square root (4 root bits per stage)
//   and the two normalizing dividers (4 quotient bits per stage) laid out
//   as pipeline stages.
//   Reset clears all valid bits and loads the register defaults.
//   When rsp_stall holds a result, the whole pipe freezes and req_stall
//   rises in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module two_phase_field_cell_update_unit
   import tpfcu_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  req_payload_type          req_payload,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output rsp_payload_type          rsp_payload,
   input  wire                      csr_write,
   input  wire [CSR_IDX_BITS-1:0]   csr_index,
   input  wire [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [GAIN_BITS-1:0]  grad_gain_ff, barrier_gain_ff, drive_gain_ff;
   logic [FIELD_BITS-1:0] equil_conc_ff;

   work_type stage_in [NUM_STAGES];
   work_type stage_ff [NUM_STAGES];
   logic [NUM_STAGES-1:0] valid_ff;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            advance;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grad_gain_ff    <= GRAD_GAIN_RST;
         barrier_gain_ff <= BARRIER_GAIN_RST;
         drive_gain_ff   <= DRIVE_GAIN_RST;
         equil_conc_ff   <= EQUIL_CONC_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GRAD_GAIN:    grad_gain_ff    <= csr_wdata;
            CSR_BARRIER_GAIN: barrier_gain_ff <= csr_wdata;
            CSR_DRIVE_GAIN:   drive_gain_ff   <= csr_wdata;
            CSR_EQUIL_CONC:   equil_conc_ff   <= csr_wdata[FIELD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // stage 0: activity test, laplacians, differences, radicand
   always_comb begin : c_stage0
      work_type w;
      logic signed [21:0] lap_s, lap_l;
      w = '0;
      w.s0 = req_payload.solid_center;
      w.l0 = req_payload.liquid_center;
      w.active = (|{req_payload.solid_center, req_payload.solid_east,
                    req_payload.solid_west, req_payload.solid_north,
                    req_payload.solid_south})
              && (|{req_payload.liquid_center, req_payload.liquid_east,
                    req_payload.liquid_west, req_payload.liquid_north,
                    req_payload.liquid_south});
      lap_s = $signed({5'b0, req_payload.solid_east}) + $signed({5'b0, req_payload.solid_west})
            + $signed({5'b0, req_payload.solid_north}) + $signed({5'b0, req_payload.solid_south})
            - $signed({3'b0, req_payload.solid_center, 2'b0});
      lap_l = $signed({5'b0, req_payload.liquid_east}) + $signed({5'b0, req_payload.liquid_west})
            + $signed({5'b0, req_payload.liquid_north})
            + $signed({5'b0, req_payload.liquid_south})
            - $signed({3'b0, req_payload.liquid_center, 2'b0});
      w.lap_diff = lap_s - lap_l;
      w.sl_diff  = $signed({1'b0, req_payload.solid_center})
                 - $signed({1'b0, req_payload.liquid_center});
      w.cdiff    = $signed({1'b0, equil_conc_ff}) - $signed({1'b0, req_payload.liquid_conc});
      w.radicand = 34'(req_payload.solid_center) * 34'(req_payload.liquid_center);
      stage_in[0] = w;
   end

   for (genvar k = 1; k < NUM_STAGES; k++) begin : g_stage
      always_comb begin : c_stage
         work_type w;
         int idx;
         logic [20:0] rsh, trial;
         logic [18:0] rds, rdl;
         logic signed [60:0] rnd61, t61;
         logic signed [44:0] rdrv;
         logic signed [48:0] rnd49, t49;
         logic signed [32:0] dd;
         logic signed [33:0] vs, vl, one_s;
         w = stage_ff[k-1];
         one_s = $signed({17'b0, ONE_VAL});
         // square root, restoring, two radicand bits per step
         if (k >= SQ_FIRST && k < SQ_FIRST + SQ_STAGES) begin
            for (int j = 0; j < SQ_STEPS; j++) begin
               idx = ROOT_BITS - 1 - ((k - SQ_FIRST) * SQ_STEPS + j);
               if (idx >= 0) begin
                  rsh   = {w.sq_rem[18:0], w.radicand[2*idx +: 2]};
                  trial = {2'b0, w.sq_root, 2'b01};
                  if (rsh >= trial) begin
                     w.sq_rem  = rsh - trial;
                     w.sq_root = {w.sq_root[ROOT_BITS-2:0], 1'b1};
                  end else begin
                     w.sq_rem  = rsh;
                     w.sq_root = {w.sq_root[ROOT_BITS-2:0], 1'b0};
                  end
               end
            end
         end
         if (k == SQ_FIRST) begin
            w.grad  = 47'($signed({1'b0, grad_gain_ff})) * 47'(w.lap_diff);
            w.barr  = 43'($signed({1'b0, barrier_gain_ff})) * 43'(w.sl_diff);
            w.dprod = 43'($signed({1'b0, drive_gain_ff})) * 43'(w.cdiff);
         end
         if (k == DRV_STAGE) begin
            w.drv = 61'(w.dprod) * 61'($signed({1'b0, w.sq_root}));
         end
         // round half away from zero: bias is one less for negatives
         if (k == ACC_STAGE) begin
            rnd61 = w.drv[60] ? 61'sh7FFF : 61'sh8000;
            t61   = w.drv + rnd61;
            rdrv  = 45'(t61 >>> FRAC_BITS);
            w.acc = 49'(w.grad) + 49'(w.barr) + 49'(rdrv);
         end
         if (k == CLAMP_STAGE) begin
            rnd49 = w.acc[48] ? 49'sh7FFF : 49'sh8000;
            t49   = w.acc + rnd49;
            dd    = 33'(t49 >>> FRAC_BITS);
            vs    = $signed({17'b0, w.s0}) + 34'(dd);
            vl    = $signed({17'b0, w.l0}) - 34'(dd);
            w.cs  = vs[33] ? '0 : (vs > one_s) ? ONE_VAL : vs[FIELD_BITS-1:0];
            w.cl  = vl[33] ? '0 : (vl > one_s) ? ONE_VAL : vl[FIELD_BITS-1:0];
         end
         if (k == NORM_STAGE) begin
            w.dsum  = {1'b0, w.cs} + {1'b0, w.cl};
            w.num_s = (34'(w.cs) << FRAC_BITS) + 34'(w.dsum >> 1);
            w.num_l = (34'(w.cl) << FRAC_BITS) + 34'(w.dsum >> 1);
            w.rem_s = {2'b0, w.num_s[33:QUO_BITS]};
            w.rem_l = {2'b0, w.num_l[33:QUO_BITS]};
            w.q_s   = '0;
            w.q_l   = '0;
         end
         // both normalizing dividers, one quotient bit per step
         if (k >= DIV_FIRST && k < DIV_FIRST + DIV_STAGES) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
               idx = QUO_BITS - 1 - ((k - DIV_FIRST) * DIV_STEPS + j);
               if (idx >= 0) begin
                  rds = {w.rem_s[17:0], w.num_s[idx]};
                  rdl = {w.rem_l[17:0], w.num_l[idx]};
                  if (rds >= {1'b0, w.dsum}) begin
                     w.rem_s    = rds - {1'b0, w.dsum};
                     w.q_s[idx] = 1'b1;
                  end else begin
                     w.rem_s = rds;
                  end
                  if (rdl >= {1'b0, w.dsum}) begin
                     w.rem_l    = rdl - {1'b0, w.dsum};
                     w.q_l[idx] = 1'b1;
                  end else begin
                     w.rem_l = rdl;
                  end
               end
            end
         end
         stage_in[k] = w;
      end
   end

   always_comb begin
      work_type f;
      f = stage_ff[NUM_STAGES-1];
      if (!f.active) begin
         rsp_payload_in.new_solid      = f.s0;
         rsp_payload_in.new_liquid     = f.l0;
         rsp_payload_in.interface_cell = 1'b0;
      end else if (f.dsum == '0) begin
         rsp_payload_in.new_solid      = '0;
         rsp_payload_in.new_liquid     = '0;
         rsp_payload_in.interface_cell = 1'b1;
      end else begin
         rsp_payload_in.new_solid      = f.q_s;
         rsp_payload_in.new_liquid     = f.q_l;
         rsp_payload_in.interface_cell = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[NUM_STAGES-2:0], req_valid};
         rsp_valid_ff <= valid_ff[NUM_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            stage_ff[k] <= stage_in[k];
         end
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

`default_nettype wire

### sv/tpfcu_checker.sv
// ----------------------------------------------------------------------------
// tpfcu_checker
// Port-level checks for the two-phase field cell update unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tpfcu_checker
   import tpfcu_pkg::*;
(
   input wire             clock,
   input wire             reset,
   input wire             req_stall,
   input wire             rsp_valid,
   input wire             rsp_stall,
   input rsp_payload_type rsp_payload
);

   logic [FIELD_BITS:0] frac_sum;
   assign frac_sum = {1'b0, rsp_payload.new_solid} + {1'b0, rsp_payload.new_liquid};

   // input side only backs up behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a held result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

   // normalized fractions of an interface cell that are not both zero add up to one within rounding
   a_norm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.interface_cell && frac_sum != '0) |->
      (frac_sum >= 18'(ONE_VAL) - 18'd1 && frac_sum <= 18'(ONE_VAL) + 18'd1))
      else $error("normalized fractions do not sum to one");

   a_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.interface_cell) |->
      (rsp_payload.new_solid <= ONE_VAL && rsp_payload.new_liquid <= ONE_VAL))
      else $error("interface fraction above one");

endmodule

bind two_phase_field_cell_update_unit tpfcu_checker u_tpfcu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
